/* src/moc_pkg.sv */
// ----------------------------------------------------------------------------
// moc_pkg
// Shared types and constants of the monomial order comparator: order codes,
// register indexes, running-sum width and the per-pair state snapshot.
// ----------------------------------------------------------------------------
package moc_pkg;

	// running degree sums saturate at this signed width
	localparam int SUM_W   = 22;
	localparam int SUM_MAX = 2097151;
	localparam int SUM_MIN = -2097152;

	// configuration port
	localparam int CFG_DATA_W  = 7;
	localparam int CFG_INDEX_W = 2;
	localparam int BLOCK_W     = 7;

	localparam logic [CFG_INDEX_W-1:0] REG_ORDER_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STRICT     = 2'd2;

	typedef enum logic [1:0] {
		ORDER_LEX       = 2'd0,
		ORDER_DEGLEX    = 2'd1,
		ORDER_DEGREVLEX = 2'd2,
		ORDER_BLOCK     = 2'd3
	} order_mode_t;

	// state of one finished vector pair, handed to the decision stage
	typedef struct packed {
		logic signed [SUM_W-1:0] head_sum_a;
		logic signed [SUM_W-1:0] head_sum_b;
		logic signed [SUM_W-1:0] tail_sum_a;
		logic signed [SUM_W-1:0] tail_sum_b;
		logic                    first_diff_seen;
		logic                    first_diff_a_greater;
		logic                    head_last_diff_seen;
		logic                    head_last_diff_a_less;
		logic                    tail_last_diff_seen;
		logic                    tail_last_diff_a_less;
	} pair_state_t;

endpackage

/* src/moc_decide.sv */
// ----------------------------------------------------------------------------
// moc_decide
// Ranks monomial A against B from the state of a finished pair under the
// configured ordering, and flags whether both vectors are equal.
// ----------------------------------------------------------------------------
module moc_decide (
	input  moc_pkg::pair_state_t pair,
	input  moc_pkg::order_mode_t order_mode,
	input  logic                 strict,
	output logic                 a_greater,
	output logic                 vectors_equal
);

	localparam int TOT_W = moc_pkg::SUM_W + 1;

	logic signed [TOT_W-1:0] deg_a;
	logic signed [TOT_W-1:0] deg_b;
	logic                    eq_result;
	logic                    lex_result;
	logic                    revlex_result;
	logic                    block_result;

	// total degrees over both blocks
	assign deg_a = TOT_W'(pair.head_sum_a) + TOT_W'(pair.tail_sum_a);
	assign deg_b = TOT_W'(pair.head_sum_b) + TOT_W'(pair.tail_sum_b);

	assign eq_result  = !strict;
	assign lex_result = pair.first_diff_seen ? pair.first_diff_a_greater : eq_result;

	// reverse lex tie break: last differing position, smaller exponent wins
	always_comb begin
		if (pair.tail_last_diff_seen) begin
			revlex_result = pair.tail_last_diff_a_less;
		end else if (pair.head_last_diff_seen) begin
			revlex_result = pair.head_last_diff_a_less;
		end else begin
			revlex_result = eq_result;
		end
	end

	// two-block order: head block first, then tail block
	always_comb begin
		if (pair.head_sum_a != pair.head_sum_b) begin
			block_result = pair.head_sum_a > pair.head_sum_b;
		end else if (pair.head_last_diff_seen) begin
			block_result = pair.head_last_diff_a_less;
		end else if (pair.tail_sum_a != pair.tail_sum_b) begin
			block_result = pair.tail_sum_a > pair.tail_sum_b;
		end else if (pair.tail_last_diff_seen) begin
			block_result = pair.tail_last_diff_a_less;
		end else begin
			block_result = eq_result;
		end
	end

	// select by ordering
	always_comb begin
		case (order_mode)
			moc_pkg::ORDER_LEX: begin
				a_greater = lex_result;
			end
			moc_pkg::ORDER_DEGLEX: begin
				a_greater = (deg_a != deg_b) ? (deg_a > deg_b) : lex_result;
			end
			moc_pkg::ORDER_DEGREVLEX: begin
				a_greater = (deg_a != deg_b) ? (deg_a > deg_b) : revlex_result;
			end
			default: begin
				a_greater = block_result;
			end
		endcase
	end

	assign vectors_equal = !pair.first_diff_seen;

endmodule

/* src/monomial_order_compare.sv */
// ----------------------------------------------------------------------------
// monomial_order_compare
// Streaming monomial order comparator: exponent pairs in, one rank result
// per vector pair out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries exp_a, exp_b and last, one
//   variable position per transfer, lowest position first. The transfer with
//   last high closes a vector pair.
//   Output channel (out_valid / out_stall) carries a_greater and
//   vectors_equal, one transfer per vector pair.
//   Throughput: one input transfer per cycle, sustained, as long as the
//   output side takes results.
//   The result of a pair passes through the input register, the pair-state
//   snapshot and the result register. Registers order_mode, block_size and
//   strict are written through wr_en / wr_index / wr_data; the user must do
//   so only while no pair is in flight, which the block does not enforce.
//   Reset clears all per-pair state and loads order_mode = degree reverse
//   lex, block_size = 16, strict = 0.
//   When the receiver stalls, the result register holds; the stages behind
//   it keep filling and in_stall rises once a closing transfer can not move.
// ----------------------------------------------------------------------------
module monomial_order_compare #(
	parameter int MAX_VARS  = 64,
	parameter int EXP_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                wr_en,
	input  logic [moc_pkg::CFG_INDEX_W-1:0]     wr_index,
	input  logic [moc_pkg::CFG_DATA_W-1:0]      wr_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [EXP_WIDTH-1:0]         exp_a,
	input  logic signed [EXP_WIDTH-1:0]         exp_b,
	input  logic                                last,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                a_greater,
	output logic                                vectors_equal
);

	localparam int SUM_W = moc_pkg::SUM_W;
	localparam int POS_W = $clog2(MAX_VARS + 1);
	localparam int CMP_W = (POS_W > moc_pkg::BLOCK_W) ? POS_W : moc_pkg::BLOCK_W;
	localparam int ADD_W = ((EXP_WIDTH > SUM_W) ? EXP_WIDTH : SUM_W) + 1;
	localparam logic [POS_W-1:0]       POS_LIMIT = POS_W'(MAX_VARS);
	localparam logic signed [ADD_W-1:0] SAT_HI   = ADD_W'(moc_pkg::SUM_MAX);
	localparam logic signed [ADD_W-1:0] SAT_LO   = ADD_W'(moc_pkg::SUM_MIN);

	// configuration registers
	moc_pkg::order_mode_t              order_mode_q;
	logic [moc_pkg::BLOCK_W-1:0]       block_size_q;
	logic                              strict_q;

	// stage 1: input register
	logic                              valid_s1;
	logic signed [EXP_WIDTH-1:0]       exp_a_s1;
	logic signed [EXP_WIDTH-1:0]       exp_b_s1;
	logic                              last_s1;

	// running per-pair state
	logic [POS_W-1:0]                  position_q;
	moc_pkg::pair_state_t              pair_q;
	moc_pkg::pair_state_t              pair_next;

	// stage 2: snapshot of a finished pair
	logic                              valid_s2;
	moc_pkg::pair_state_t              pair_s2;

	// result register
	logic                              out_valid_q;
	logic                              a_greater_q;
	logic                              vectors_equal_q;
	logic                              dec_a_greater;
	logic                              dec_vectors_equal;

	// handshake
	logic                              ready_out;
	logic                              ready_s2;
	logic                              fire_s1;
	logic                              ready_s1;
	logic                              in_xfer;

	// datapath of the update step
	logic                              in_head;
	logic                              differ;
	logic signed [ADD_W-1:0]           raw_a;
	logic signed [ADD_W-1:0]           raw_b;
	logic signed [SUM_W-1:0]           sat_a;
	logic signed [SUM_W-1:0]           sat_b;

	// backpressure chain
	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s2  = !valid_s2 || ready_out;
	assign fire_s1   = valid_s1 && (!last_s1 || ready_s2);
	assign ready_s1  = !valid_s1 || fire_s1;
	assign in_stall  = !ready_s1;
	assign in_xfer   = in_valid && ready_s1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= moc_pkg::ORDER_DEGREVLEX;
			block_size_q <= moc_pkg::BLOCK_W'(16);
			strict_q     <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				moc_pkg::REG_ORDER_MODE: order_mode_q <= moc_pkg::order_mode_t'(wr_data[1:0]);
				moc_pkg::REG_BLOCK_SIZE: block_size_q <= wr_data[moc_pkg::BLOCK_W-1:0];
				moc_pkg::REG_STRICT:     strict_q     <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	// capture input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			exp_a_s1 <= exp_a;
			exp_b_s1 <= exp_b;
			last_s1  <= last;
		end
	end

	// add into the head or tail block and saturate
	assign in_head = CMP_W'(position_q) < CMP_W'(block_size_q);
	assign differ  = exp_a_s1 != exp_b_s1;
	assign raw_a   = ADD_W'(in_head ? pair_q.head_sum_a : pair_q.tail_sum_a) + ADD_W'(exp_a_s1);
	assign raw_b   = ADD_W'(in_head ? pair_q.head_sum_b : pair_q.tail_sum_b) + ADD_W'(exp_b_s1);

	always_comb begin
		if (raw_a > SAT_HI) begin
			sat_a = SUM_W'(SAT_HI);
		end else if (raw_a < SAT_LO) begin
			sat_a = SUM_W'(SAT_LO);
		end else begin
			sat_a = SUM_W'(raw_a);
		end
		if (raw_b > SAT_HI) begin
			sat_b = SUM_W'(SAT_HI);
		end else if (raw_b < SAT_LO) begin
			sat_b = SUM_W'(SAT_LO);
		end else begin
			sat_b = SUM_W'(raw_b);
		end
	end

	// update sums and difference flags for the current position
	always_comb begin
		pair_next = pair_q;
		if (in_head) begin
			pair_next.head_sum_a = sat_a;
			pair_next.head_sum_b = sat_b;
		end else begin
			pair_next.tail_sum_a = sat_a;
			pair_next.tail_sum_b = sat_b;
		end
		if (differ) begin
			if (!pair_q.first_diff_seen) begin
				pair_next.first_diff_seen      = 1'b1;
				pair_next.first_diff_a_greater = exp_a_s1 > exp_b_s1;
			end
			if (in_head) begin
				pair_next.head_last_diff_seen   = 1'b1;
				pair_next.head_last_diff_a_less = exp_a_s1 < exp_b_s1;
			end else begin
				pair_next.tail_last_diff_seen   = 1'b1;
				pair_next.tail_last_diff_a_less = exp_a_s1 < exp_b_s1;
			end
		end
	end

	// advance running state, clear it when a pair closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			pair_q     <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				position_q <= '0;
				pair_q     <= '0;
			end else begin
				pair_q <= pair_next;
				if (position_q != POS_LIMIT) begin
					position_q <= position_q + POS_W'(1);
				end
			end
		end
	end

	// hand the finished pair to the decision stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= fire_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && fire_s1 && last_s1) begin
			pair_s2 <= pair_next;
		end
	end

	moc_decide u_decide (
		.pair          (pair_s2),
		.order_mode    (order_mode_q),
		.strict        (strict_q),
		.a_greater     (dec_a_greater),
		.vectors_equal (dec_vectors_equal)
	);

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_s2) begin
			a_greater_q     <= dec_a_greater;
			vectors_equal_q <= dec_vectors_equal;
		end
	end

	assign out_valid     = out_valid_q;
	assign a_greater     = a_greater_q;
	assign vectors_equal = vectors_equal_q;

endmodule

/* bench/tb_monomial_order_compare.sv */
// ----------------------------------------------------------------------------
// tb_monomial_order_compare
// Self-checking bench for the streaming monomial order comparator. Exponent
// pairs go in one position per transfer; a local predictor tracks the degree
// sums and difference flags of each pair. It ranks the pair under the current
// order and queues the result that the block must return. Both channels idle
// and stall at random. Registers change only while the block is drained.
// ----------------------------------------------------------------------------
module tb_monomial_order_compare;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VARS = 64;
	localparam int EW   = 16;

	typedef logic signed [EW-1:0] expo_t;

	typedef struct {
		bit a_greater;
		bit equal;
	} rank_t;

	typedef enum int {
		SHAPE_EQUAL,
		SHAPE_SWAP,
		SHAPE_NUDGE,
		SHAPE_SMALL,
		SHAPE_WIDE,
		SHAPE_EXTREME,
		SHAPE_RAIL
	} shape_t;

	logic                            clk;
	logic                            arst_n;
	logic                            wr_en;
	logic [moc_pkg::CFG_INDEX_W-1:0] wr_index;
	logic [moc_pkg::CFG_DATA_W-1:0]  wr_data;
	logic                            in_valid;
	logic                            in_stall;
	expo_t                           exp_a;
	expo_t                           exp_b;
	logic                            last;
	logic                            out_valid;
	logic                            out_stall;
	logic                            a_greater;
	logic                            vectors_equal;

	// ranks still owed by the block, oldest first
	rank_t rank_q[$];
	int    errors;
	bit    calm;

	// predictor copy of the registers
	moc_pkg::order_mode_t ord_mode;
	logic [6:0]           head_len;
	bit                   strict_eq;

	// predictor copy of the per-pair state
	logic [6:0] pos;
	longint     hsa, hsb, tsa, tsb;
	bit         diff_seen, diff_a_greater;
	bit         head_diff_seen, head_diff_a_less;
	bit         tail_diff_seen, tail_diff_a_less;

	// run statistics
	int items_sent;
	int pairs_per_mode[4];
	int equal_pairs;
	int cur_len;
	int longest;

	// vector pair under construction
	expo_t pa[$];
	expo_t pb[$];

	monomial_order_compare #(
		.MAX_VARS (VARS),
		.EXP_WIDTH(EW)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.exp_a        (exp_a),
		.exp_b        (exp_b),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.a_greater    (a_greater),
		.vectors_equal(vectors_equal)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_monomial_order_compare: errors");
		$finish;
	end

	// ------------------------------------------------------------------ model

	function automatic longint clamp_sum(longint s);
		if (s > moc_pkg::SUM_MAX)
			return moc_pkg::SUM_MAX;
		if (s < moc_pkg::SUM_MIN)
			return moc_pkg::SUM_MIN;
		return s;
	endfunction

	task automatic clear_pair_state();
		pos = '0;
		hsa = 0;
		hsb = 0;
		tsa = 0;
		tsb = 0;
		diff_seen = 0;
		diff_a_greater = 0;
		head_diff_seen = 0;
		head_diff_a_less = 0;
		tail_diff_seen = 0;
		tail_diff_a_less = 0;
		cur_len = 0;
	endtask

	function automatic bit rank_a_over_b();
		longint da, db;
		da = hsa + tsa;
		db = hsb + tsb;
		case (ord_mode)
			moc_pkg::ORDER_LEX: begin
				return diff_seen ? diff_a_greater : !strict_eq;
			end
			moc_pkg::ORDER_DEGLEX: begin
				if (da != db)
					return da > db;
				return diff_seen ? diff_a_greater : !strict_eq;
			end
			moc_pkg::ORDER_DEGREVLEX: begin
				if (da != db)
					return da > db;
				if (tail_diff_seen)
					return tail_diff_a_less;
				if (head_diff_seen)
					return head_diff_a_less;
				return !strict_eq;
			end
			default: begin
				if (hsa != hsb)
					return hsa > hsb;
				if (head_diff_seen)
					return head_diff_a_less;
				if (tsa != tsb)
					return tsa > tsb;
				if (tail_diff_seen)
					return tail_diff_a_less;
				return !strict_eq;
			end
		endcase
	endfunction

	// fold one accepted position into the pair state; rank on the last one
	task automatic take_exponents(expo_t a, expo_t b, bit lst);
		longint va, vb;
		bit     in_head;
		rank_t  r;
		va = a;
		vb = b;
		in_head = pos < head_len;
		if (in_head) begin
			hsa = clamp_sum(hsa + va);
			hsb = clamp_sum(hsb + vb);
		end else begin
			tsa = clamp_sum(tsa + va);
			tsb = clamp_sum(tsb + vb);
		end
		if (va != vb) begin
			if (!diff_seen) begin
				diff_seen = 1;
				diff_a_greater = va > vb;
			end
			if (in_head) begin
				head_diff_seen = 1;
				head_diff_a_less = va < vb;
			end else begin
				tail_diff_seen = 1;
				tail_diff_a_less = va < vb;
			end
		end
		if (pos < VARS)
			pos = pos + 7'd1;
		cur_len++;
		if (lst) begin
			r.a_greater = rank_a_over_b();
			r.equal = !diff_seen;
			rank_q.insert(rank_q.size(), r);
			pairs_per_mode[int'(ord_mode)]++;
			if (r.equal)
				equal_pairs++;
			if (cur_len > longest)
				longest = cur_len;
			clear_pair_state();
		end
	endtask

	// ---------------------------------------------------------------- drivers

	// mostly back to back, sometimes short holes, rarely long ones
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// random stall runs on the result side
	initial begin
		int left;
		bit hold;
		out_stall <= 1'b0;
		left = 0;
		forever begin
			@(posedge clk);
			if (left > 0) begin
				left--;
			end else begin
				hold = !calm && ($urandom_range(0, 2) == 0);
				left = hold ? pick_gap() : $urandom_range(0, 6);
				out_stall <= hold;
			end
		end
	end

	task automatic report_mismatch(string msg);
		if (errors < 40)
			$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	// compare each result transfer with the oldest pending rank
	always @(posedge clk) begin
		rank_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (rank_q.size() == 0) begin
				report_mismatch($sformatf("result a_greater=%b vectors_equal=%b with none pending",
					a_greater, vectors_equal));
			end else begin
				want = rank_q.pop_front();
				if (a_greater !== want.a_greater)
					report_mismatch($sformatf("a_greater expected %0d, got %b",
						want.a_greater, a_greater));
				if (vectors_equal !== want.equal)
					report_mismatch($sformatf("vectors_equal expected %0d, got %b",
						want.equal, vectors_equal));
			end
		end
	end

	// offer one position and hold it until the transfer happens
	task automatic send_exp(expo_t a, expo_t b, bit lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		exp_a <= a;
		exp_b <= b;
		last <= lst;
		do @(posedge clk); while (in_stall);
		take_exponents(a, b, lst);
		items_sent++;
	endtask

	// stop sending, wait for every pending rank, then let the pipe settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (rank_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_cfg(moc_pkg::order_mode_t m, int blk, bit s);
		wr_en <= 1'b1;
		wr_index <= moc_pkg::REG_ORDER_MODE;
		wr_data <= moc_pkg::CFG_DATA_W'(m);
		@(posedge clk);
		wr_index <= moc_pkg::REG_BLOCK_SIZE;
		wr_data <= moc_pkg::CFG_DATA_W'(blk);
		@(posedge clk);
		wr_index <= moc_pkg::REG_STRICT;
		wr_data <= moc_pkg::CFG_DATA_W'(s);
		@(posedge clk);
		wr_en <= 1'b0;
		ord_mode = m;
		head_len = 7'(blk);
		strict_eq = s;
	endtask

	// ------------------------------------------------------------- generators

	function automatic expo_t extreme_exp();
		case ($urandom_range(0, 4))
			0: return expo_t'(32767);
			1: return expo_t'(-32768);
			2: return expo_t'(0);
			3: return expo_t'(-1);
			default: return expo_t'(1);
		endcase
	endfunction

	function automatic shape_t random_shape();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return SHAPE_EQUAL;
		if (r < 35)
			return SHAPE_SWAP;
		if (r < 55)
			return SHAPE_NUDGE;
		if (r < 80)
			return SHAPE_SMALL;
		if (r < 90)
			return SHAPE_WIDE;
		return SHAPE_EXTREME;
	endfunction

	// build a vector pair of the given length in pa / pb
	task automatic make_pair(int len, shape_t shape);
		int    k, i, j, d;
		expo_t v, r;
		pa.delete();
		pb.delete();
		r = $urandom_range(0, 1) ? expo_t'(32767) : expo_t'(-32768);
		for (k = 0; k < len; k++) begin
			case (shape)
				SHAPE_SMALL: begin
					v = expo_t'($urandom_range(0, 9));
					pa.insert(pa.size(), v);
					pb.insert(pb.size(),
						($urandom_range(0, 2) == 0) ? v : expo_t'($urandom_range(0, 9)));
				end
				SHAPE_WIDE: begin
					pa.insert(pa.size(), expo_t'($urandom()));
					pb.insert(pb.size(), expo_t'($urandom()));
				end
				SHAPE_EXTREME: begin
					pa.insert(pa.size(), extreme_exp());
					pb.insert(pb.size(), extreme_exp());
				end
				SHAPE_RAIL: begin
					pa.insert(pa.size(), r);
					pb.insert(pb.size(), r);
				end
				default: begin
					v = expo_t'($urandom_range(0, 9));
					pa.insert(pa.size(), v);
					pb.insert(pb.size(), v);
				end
			endcase
		end
		i = $urandom_range(0, len - 1);
		// swap keeps the degree and shifts weight between two positions; nudge and rail change one
		if (shape == SHAPE_SWAP && len >= 2) begin
			j = (i + $urandom_range(1, len - 1)) % len;
			d = $urandom_range(1, 3);
			pb[i] = pb[i] + expo_t'(d);
			pb[j] = pb[j] - expo_t'(d);
		end else if (shape == SHAPE_SWAP || shape == SHAPE_NUDGE) begin
			pb[i] = pb[i] + ($urandom_range(0, 1) ? expo_t'(1) : expo_t'(-1));
		end else if (shape == SHAPE_RAIL) begin
			pb[i] = extreme_exp();
		end
	endtask

	task automatic send_pair();
		int k;
		for (k = 0; k < pa.size(); k++)
			send_exp(pa[k], pb[k], k == pa.size() - 1);
	endtask

	// ------------------------------------------------------------------ tests

	// extremes, every order, strict, empty head block, all-head block
	task automatic test_directed();
		// reset settings: degree reverse lex, head of 16, not strict
		send_exp(5, 3, 1);
		send_exp(3, 5, 1);
		send_exp(32767, -32768, 1);
		send_exp(-32768, 32767, 1);
		send_exp(0, 0, 1);
		send_exp(1, 0, 0);
		send_exp(0, 1, 0);
		send_exp(2, 2, 1);
		send_exp(-1, -1, 0);
		send_exp(7, 7, 1);
		drain_results();

		write_cfg(moc_pkg::ORDER_LEX, 1, 1);
		send_exp(0, 0, 1);
		send_exp(2, 2, 0);
		send_exp(1, 3, 0);
		send_exp(9, 0, 1);
		send_exp(-32768, -32768, 1);
		drain_results();

		// empty head block
		write_cfg(moc_pkg::ORDER_BLOCK, 0, 0);
		send_exp(1, 2, 0);
		send_exp(3, 2, 1);
		drain_results();

		// head block longer than any vector
		write_cfg(moc_pkg::ORDER_DEGLEX, 127, 1);
		send_exp(1, 2, 0);
		send_exp(2, 1, 1);
	endtask

	// random pairs under a sweep of register settings
	task automatic test_order_settings();
		moc_pkg::order_mode_t modes[12] = '{moc_pkg::ORDER_LEX, moc_pkg::ORDER_LEX,
			moc_pkg::ORDER_DEGLEX, moc_pkg::ORDER_DEGLEX,
			moc_pkg::ORDER_DEGREVLEX, moc_pkg::ORDER_DEGREVLEX,
			moc_pkg::ORDER_BLOCK, moc_pkg::ORDER_BLOCK,
			moc_pkg::ORDER_BLOCK, moc_pkg::ORDER_BLOCK,
			moc_pkg::ORDER_BLOCK, moc_pkg::ORDER_DEGREVLEX};
		int blks[12]   = '{16, 1, 5, 64, 3, 16, 1, 4, 0, 127, 8, 127};
		bit stricts[12] = '{0, 1, 0, 1, 1, 0, 0, 1, 0, 1, 0, 0};
		int p, start, len;
		bit paused;
		for (p = 0; p < 12; p++) begin
			drain_results();
			write_cfg(modes[p], blks[p], stricts[p]);
			calm = (p % 3 == 2);
			start = items_sent;
			paused = 0;
			while (items_sent - start < 55) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
				make_pair(len, random_shape());
				send_pair();
				// hold the sender once per phase until the results catch up
				if (!paused && items_sent - start >= 27) begin
					drain_results();
					paused = 1;
				end
			end
			calm = 0;
		end
	endtask

	// vectors past MAX_VARS and sums driven into saturation
	task automatic test_long_vectors();
		moc_pkg::order_mode_t modes[5] = '{moc_pkg::ORDER_BLOCK, moc_pkg::ORDER_DEGREVLEX,
			moc_pkg::ORDER_LEX, moc_pkg::ORDER_BLOCK, moc_pkg::ORDER_DEGLEX};
		int     blks[5]    = '{64, 16, 64, 127, 10};
		bit     stricts[5] = '{0, 1, 0, 0, 1};
		shape_t shapes[5]  = '{SHAPE_RAIL, SHAPE_EXTREME, SHAPE_RAIL, SHAPE_SWAP, SHAPE_RAIL};
		int p;
		for (p = 0; p < 5; p++) begin
			drain_results();
			write_cfg(modes[p], blks[p], stricts[p]);
			make_pair($urandom_range(66, 80), shapes[p]);
			send_pair();
		end
	endtask

	// ------------------------------------------------------------------- main

	initial begin
		errors = 0;
		calm = 0;
		items_sent = 0;
		equal_pairs = 0;
		longest = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		exp_a <= '0;
		exp_b <= '0;
		last <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= moc_pkg::REG_ORDER_MODE;
		wr_data <= '0;
		ord_mode = moc_pkg::ORDER_DEGREVLEX;
		head_len = 7'd16;
		strict_eq = 0;
		clear_pair_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_order_settings();
		test_long_vectors();
		drain_results();

		$display("covered %0d transfers in %0d pairs: lex %0d, deglex %0d, degrevlex %0d, block %0d",
			items_sent, pairs_per_mode[0] + pairs_per_mode[1] + pairs_per_mode[2] +
			pairs_per_mode[3], pairs_per_mode[0], pairs_per_mode[1], pairs_per_mode[2],
			pairs_per_mode[3]);
		$display("%0d pairs were equal, longest pair ran %0d positions", equal_pairs, longest);
		if (errors == 0)
			$display("tb_monomial_order_compare: clean");
		else
			$display("tb_monomial_order_compare: errors");
		$finish;
	end

endmodule

/* sim.f */
src/moc_pkg.sv
src/moc_decide.sv
src/monomial_order_compare.sv
bench/tb_monomial_order_compare.sv
